/* design/cad_pkg.sv */
// Shared opcodes, status codes, cell control struct and defaults for the deque.
`default_nettype none
package cad_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int DATA_W = 32;
  localparam int COUNT_W = 4;

  localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
  localparam logic [1:0] OP_PUSH_REAR  = 2'd1;
  localparam logic [1:0] OP_POP_FRONT  = 2'd2;
  localparam logic [1:0] OP_POP_REAR   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [DATA_W-1:0] POP_ERR_VALUE = '1;

  // one-cycle command broadcast to every cell
  typedef struct packed {
    logic push_front;
    logic push_rear;
    logic pop_front;
    logic pop_rear;
  } cell_ctrl_t;

endpackage
`default_nettype wire

/* design/cad_cell.sv */
// One deque cell: holds one element, shifts with its neighbors, and carries the return lane.
`default_nettype none
module cad_cell (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire cad_pkg::cell_ctrl_t       ctrl,
  input  wire logic [cad_pkg::DATA_W-1:0] value,
  input  wire logic [cad_pkg::DATA_W-1:0] left_data,
  input  wire logic                      left_valid,
  input  wire logic [cad_pkg::DATA_W-1:0] right_data,
  input  wire logic                      right_valid,
  input  wire logic [cad_pkg::DATA_W-1:0] right_ret_data,
  input  wire logic                      right_ret_valid,
  output logic [cad_pkg::DATA_W-1:0]     data,
  output logic                           valid,
  output logic [cad_pkg::DATA_W-1:0]     ret_data,
  output logic                           ret_valid
);

  logic last;
  logic take;

  // rear element of the chain
  assign last = valid & ~right_valid;
  assign take = ctrl.pop_rear & last;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.push_front) begin
      valid <= left_valid;
    end else if (ctrl.push_rear) begin
      if (left_valid && !valid) begin
        valid <= 1'b1;
      end
    end else if (ctrl.pop_front) begin
      valid <= right_valid;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push_front) begin
      data <= left_data;
    end else if (ctrl.push_rear && left_valid && !valid) begin
      data <= value;
    end else if (ctrl.pop_front) begin
      data <= right_data;
    end
  end

  // return lane walks a popped rear value toward cell 0
  always_ff @(posedge clk) begin
    if (rst) begin
      ret_valid <= 1'b0;
    end else begin
      ret_valid <= take | right_ret_valid;
    end
  end

  always_ff @(posedge clk) begin
    ret_data <= take ? data : right_ret_data;
  end

endmodule
`default_nettype wire

/* design/circular_array_deque.sv */
// Top level of the deque: request control, element counter and the row of cells.
// Push front, push rear, pop front and pop rear on an empty deque: result valid
// the cycle after the transfer in. Pop rear with elements stored: the popped
// value walks the return lane from the rear cell to cell 0, one cell per cycle,
// and is then registered as the result.
// The block takes no new request until the previous result is transferred out.
// Reset (rst, synchronous) empties the deque; cell contents are not cleared.
`default_nettype none
module circular_array_deque #(
  parameter int DEPTH = cad_pkg::DEPTH_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              req_valid,
  output logic                                   req_stall,
  input  wire logic [1:0]                        opcode,
  input  wire logic signed [cad_pkg::DATA_W-1:0] value,
  output logic                                   rsp_valid,
  input  wire logic                              rsp_stall,
  output logic signed [cad_pkg::DATA_W-1:0]      popped_value,
  output logic [1:0]                             status,
  output logic [cad_pkg::COUNT_W-1:0]            count,
  output logic                                   is_empty,
  output logic                                   is_full
);

  localparam int N = DEPTH - 1;
  localparam int CW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int DW = cad_pkg::DATA_W;

  typedef enum logic [2:0] {
    S_IDLE     = 3'b001,
    S_POP_WAIT = 3'b010,
    S_OUT      = 3'b100
  } state_t;

  state_t state, state_next;

  logic [CW-1:0] cnt, cnt_next;
  logic          full, empty, accept, err;
  cad_pkg::cell_ctrl_t ctrl;

  logic [DW-1:0] cell_data  [N];
  logic          cell_valid [N];
  logic [DW-1:0] ret_data   [N];
  logic          ret_valid  [N];

  logic [CW+cad_pkg::COUNT_W-1:0] cnt_ext;

  assign full   = (cnt == CW'(N));
  assign empty  = (cnt == '0);
  assign accept = req_valid & ~req_stall;
  assign req_stall = (state != S_IDLE);
  assign rsp_valid = (state == S_OUT);

  always_comb begin
    err = 1'b0;
    case (opcode)
      cad_pkg::OP_PUSH_FRONT, cad_pkg::OP_PUSH_REAR: err = full;
      cad_pkg::OP_POP_FRONT, cad_pkg::OP_POP_REAR:   err = empty;
      default:                                       err = 1'b0;
    endcase
  end

  always_comb begin
    ctrl = '0;
    if (accept && !err) begin
      case (opcode)
        cad_pkg::OP_PUSH_FRONT: ctrl.push_front = 1'b1;
        cad_pkg::OP_PUSH_REAR:  ctrl.push_rear  = 1'b1;
        cad_pkg::OP_POP_FRONT:  ctrl.pop_front  = 1'b1;
        cad_pkg::OP_POP_REAR:   ctrl.pop_rear   = 1'b1;
        default:                ctrl = '0;
      endcase
    end
  end

  always_comb begin
    cnt_next = cnt;
    if (ctrl.push_front || ctrl.push_rear) begin
      cnt_next = cnt + CW'(1);
    end else if (ctrl.pop_front || ctrl.pop_rear) begin
      cnt_next = cnt - CW'(1);
    end
  end

  assign cnt_ext = {{cad_pkg::COUNT_W{1'b0}}, cnt_next};

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = ctrl.pop_rear ? S_POP_WAIT : S_OUT;
        end
      end
      S_POP_WAIT: begin
        if (ret_valid[0]) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!rsp_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // result fields; count and flags are settled at the transfer in
  always_ff @(posedge clk) begin
    if (accept) begin
      count    <= cnt_ext[cad_pkg::COUNT_W-1:0];
      is_empty <= (cnt_next == '0);
      is_full  <= (cnt_next == CW'(N));
      if (err) begin
        popped_value <= (opcode inside {cad_pkg::OP_POP_FRONT, cad_pkg::OP_POP_REAR})
                        ? cad_pkg::POP_ERR_VALUE : '0;
        status <= (opcode inside {cad_pkg::OP_POP_FRONT, cad_pkg::OP_POP_REAR})
                  ? cad_pkg::ST_EMPTY : cad_pkg::ST_FULL;
      end else begin
        popped_value <= ctrl.pop_front ? cell_data[0] : '0;
        status       <= cad_pkg::ST_OK;
      end
    end else if (state == S_POP_WAIT && ret_valid[0]) begin
      popped_value <= ret_data[0];
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [DW-1:0] l_data, r_data, r_ret_data;
    logic          l_valid, r_valid, r_ret_valid;

    if (i == 0) begin : g_first
      assign l_data  = value;
      assign l_valid = 1'b1;
    end else begin : g_mid_l
      assign l_data  = cell_data[i-1];
      assign l_valid = cell_valid[i-1];
    end

    if (i == N - 1) begin : g_last
      assign r_data      = '0;
      assign r_valid     = 1'b0;
      assign r_ret_data  = '0;
      assign r_ret_valid = 1'b0;
    end else begin : g_mid_r
      assign r_data      = cell_data[i+1];
      assign r_valid     = cell_valid[i+1];
      assign r_ret_data  = ret_data[i+1];
      assign r_ret_valid = ret_valid[i+1];
    end

    cad_cell u_cell (
      .clk             (clk),
      .rst             (rst),
      .ctrl            (ctrl),
      .value           (value),
      .left_data       (l_data),
      .left_valid      (l_valid),
      .right_data      (r_data),
      .right_valid     (r_valid),
      .right_ret_data  (r_ret_data),
      .right_ret_valid (r_ret_valid),
      .data            (cell_data[i]),
      .valid           (cell_valid[i]),
      .ret_data        (ret_data[i]),
      .ret_valid       (ret_valid[i])
    );
  end

endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
// Testbench for circular_array_deque: directed and random requests checked against a behavioral deque.
module tb_top;
  import cad_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;
  localparam int LIMIT_CYCLES = 100000;
  localparam int MAX_REPORTS = 10;
  localparam logic [DATA_W-1:0] EDGE_VALUES [5] = '{
    32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001
  };

  typedef struct packed {
    logic [DATA_W-1:0]  popped_value;
    logic [1:0]         status;
    logic [COUNT_W-1:0] count;
    logic               is_empty;
    logic               is_full;
  } deque_result_t;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     req_valid = 1'b0;
  logic                     req_stall;
  logic [1:0]               opcode = OP_PUSH_FRONT;
  logic signed [DATA_W-1:0] value = '0;
  logic                     rsp_valid;
  logic                     rsp_stall = 1'b0;
  logic signed [DATA_W-1:0] popped_value;
  logic [1:0]               status;
  logic [COUNT_W-1:0]       count;
  logic                     is_empty;
  logic                     is_full;

  circular_array_deque #(.DEPTH(DEPTH)) i_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .opcode(opcode),
    .value(value),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .popped_value(popped_value),
    .status(status),
    .count(count),
    .is_empty(is_empty),
    .is_full(is_full)
  );

  // behavioral deque: front_ptr one slot before the first element, back_ptr on the last
  logic [DATA_W-1:0] ring_slots [DEPTH];
  int                front_ptr = 0;
  int                back_ptr = 0;
  deque_result_t     expected_results[$];

  int          src_idle_pct = 0;
  int          sink_idle_pct = 0;
  int          hold_request = 0;
  int          hold_left = 0;
  int          error_count = 0;
  int unsigned cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int ring_step(int p, int delta);
    return (p + delta + DEPTH) % DEPTH;
  endfunction

  function automatic void predict_request(logic [1:0] op, logic [DATA_W-1:0] val);
    deque_result_t r;
    int            n;
    bit            now_full;
    bit            now_empty;
    now_full = (front_ptr == ring_step(back_ptr, 1));
    now_empty = (front_ptr == back_ptr);
    r.popped_value = '0;
    r.status = ST_OK;
    case (op)
      OP_PUSH_FRONT: begin
        if (now_full) begin
          r.status = ST_FULL;
        end else begin
          ring_slots[front_ptr] = val;
          front_ptr = ring_step(front_ptr, -1);
        end
      end
      OP_PUSH_REAR: begin
        if (now_full) begin
          r.status = ST_FULL;
        end else begin
          back_ptr = ring_step(back_ptr, 1);
          ring_slots[back_ptr] = val;
        end
      end
      OP_POP_FRONT: begin
        if (now_empty) begin
          r.status = ST_EMPTY;
          r.popped_value = POP_ERR_VALUE;
        end else begin
          front_ptr = ring_step(front_ptr, 1);
          r.popped_value = ring_slots[front_ptr];
        end
      end
      default: begin
        if (now_empty) begin
          r.status = ST_EMPTY;
          r.popped_value = POP_ERR_VALUE;
        end else begin
          r.popped_value = ring_slots[back_ptr];
          back_ptr = ring_step(back_ptr, -1);
        end
      end
    endcase
    n = (back_ptr - front_ptr + DEPTH) % DEPTH;
    r.count = n[COUNT_W-1:0];
    r.is_empty = (n == 0);
    r.is_full = (front_ptr == ring_step(back_ptr, 1));
    expected_results.push_back(r);
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    if ($urandom_range(7, 0) == 0) begin
      return EDGE_VALUES[$urandom_range(4, 0)];
    end
    return $urandom;
  endfunction

  // valid stays high between back-to-back transfers; lowered only for a gap
  task automatic send_request(input logic [1:0] op, input logic [DATA_W-1:0] val);
    if ($urandom_range(99, 0) < src_idle_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    req_valid <= 1'b1;
    opcode <= op;
    value <= val;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predict_request(op, val);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(99, 0) < sink_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : check_results
    deque_result_t got;
    deque_result_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      got = {popped_value, status, count, is_empty, is_full};
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("unexpected result at cycle %0d: popped %h status %0d count %0d",
                   cycle_count, got.popped_value, got.status, got.count);
        end
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("mismatch at cycle %0d (expected/actual): popped %h/%h status %0d/%0d",
                     cycle_count, want.popped_value, got.popped_value,
                     want.status, got.status);
            $display("  count %0d/%0d empty %b/%b full %b/%b",
                     want.count, got.count, want.is_empty, got.is_empty,
                     want.is_full, got.is_full);
          end
        end
      end
    end
  end

  task automatic test_empty_pops;
    src_idle_pct = 30;
    sink_idle_pct = 30;
    send_request(OP_POP_FRONT, 32'h5555_5555);
    send_request(OP_POP_REAR, 32'hAAAA_AAAA);
    send_request(OP_PUSH_REAR, 32'hAAAA_AAAA);
    send_request(OP_POP_REAR, 32'h0);
    send_request(OP_POP_FRONT, 32'h0);
  endtask

  task automatic test_fill_and_overflow;
    logic [1:0] op;
    for (int i = 0; i < DEPTH - 1; i++) begin
      op = i[0] ? OP_PUSH_REAR : OP_PUSH_FRONT;
      send_request(op, (i < 5) ? EDGE_VALUES[i] : $urandom);
    end
    send_request(OP_PUSH_FRONT, 32'h1234_5678);
    send_request(OP_PUSH_REAR, 32'h8765_4321);
    send_request(OP_POP_FRONT, 32'h0);
    send_request(OP_POP_REAR, 32'h0);
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_backpressure;
    src_idle_pct = 0;
    sink_idle_pct = 0;
    hold_request = 120;
    for (int i = 0; i < 12; i++) begin
      send_request(2'($urandom_range(3, 0)), pick_value());
    end
  endtask

  task automatic test_random_mix;
    int         push_pct;
    logic [1:0] op;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: push_pct = 80;
        2: push_pct = 20;
        default: push_pct = 50;
      endcase
      src_idle_pct = (phase == 2 || phase == 3) ? 0 : 30;
      sink_idle_pct = src_idle_pct;
      for (int i = 0; i < 50; i++) begin
        if ($urandom_range(99, 0) < push_pct) begin
          op = $urandom_range(1, 0) ? OP_PUSH_REAR : OP_PUSH_FRONT;
        end else begin
          op = $urandom_range(1, 0) ? OP_POP_REAR : OP_POP_FRONT;
        end
        send_request(op, pick_value());
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_pops();
    test_fill_and_overflow();
    test_backpressure();
    test_random_mix();
    req_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DEPTH + 20) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
